[design/zmpc_pkg.sv]
`default_nettype none
package zmpc_pkg;

  localparam int unsigned BoundWidth = 64;

  typedef logic [BoundWidth-1:0] bound_t;

  typedef enum logic [3:0] {
    OP_FALSE   = 4'd0,
    OP_TRUE    = 4'd1,
    OP_ISNULL  = 4'd2,
    OP_NOTNULL = 4'd3,
    OP_EQ      = 4'd4,
    OP_NE      = 4'd5,
    OP_LT      = 4'd6,
    OP_LE      = 4'd7,
    OP_GT      = 4'd8,
    OP_GE      = 4'd9,
    OP_BETW    = 4'd10,
    OP_NBETW   = 4'd11,
    OP_LIKE    = 4'd12,
    OP_NLIKE   = 4'd13
  } op_t;

  typedef enum logic [1:0] {
    V_NONE = 2'd0,
    V_SOME = 2'd1,
    V_ALL  = 2'd2
  } verdict_t;

  localparam logic [1:0] REG_NULL = 2'd0;
  localparam logic [1:0] REG_MINF = 2'd1;
  localparam logic [1:0] REG_PINF = 2'd2;

  localparam bound_t SIGN_BIT = {1'b1, {(BoundWidth-1){1'b0}}};
  localparam bound_t NEG_INF  = 64'hFFF0_0000_0000_0000;
  localparam bound_t POS_INF  = 64'h7FF0_0000_0000_0000;

  // Compare result between two bounds.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  // Per-item control carried from front end.
  typedef struct packed {
    logic     decided;
    verdict_t early;
    op_t      op;
    logic     demote;
  } ctl_t;

  function automatic logic is_nan(input bound_t b);
    return (b[62:52] == 11'h7FF) && (b[51:0] != '0);
  endfunction

  function automatic logic is_zero(input bound_t b);
    return b[62:0] == '0;
  endfunction

  // Signed integer or IEEE double compare of a against b.
  function automatic cmp_t compare(input bound_t a, input bound_t b, input logic fp);
    cmp_t   c;
    logic   mag_lt;
    logic   nan;
    logic   zz;
    mag_lt = a[62:0] < b[62:0];
    nan    = is_nan(a) || is_nan(b);
    zz     = is_zero(a) && is_zero(b);
    if (!fp) begin
      c.lt = $signed(a) < $signed(b);
      c.eq = a == b;
    end else if (nan) begin
      c.lt = 1'b0;
      c.eq = 1'b0;
    end else if (zz) begin
      c.lt = 1'b0;
      c.eq = 1'b1;
    end else begin
      c.eq = a == b;
      priority if (a[63] != b[63]) begin
        c.lt = a[63];
      end else if (a[63]) begin
        c.lt = (b[62:0] < a[62:0]);
      end else begin
        c.lt = mag_lt;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[design/zmpc_front.sv]
`default_nettype none
module zmpc_front (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [3:0]      mode,
  input  wire logic            is_float,
  input  wire zmpc_pkg::bound_t col_min,
  input  wire zmpc_pkg::bound_t col_max,
  input  wire zmpc_pkg::bound_t first_min,
  input  wire zmpc_pkg::bound_t first_max,
  input  wire zmpc_pkg::bound_t second_min,
  input  wire zmpc_pkg::bound_t second_max,
  input  wire logic [5:0]      null_flags,
  input  wire logic [4:0]      operand_flags,
  input  wire zmpc_pkg::bound_t null_code,
  input  wire zmpc_pkg::bound_t minus_inf_code,
  input  wire zmpc_pkg::bound_t plus_inf_code,
  output zmpc_pkg::ctl_t       ctl,
  output logic                 fp,
  output zmpc_pkg::bound_t     k0,
  output zmpc_pkg::bound_t     k1,
  output zmpc_pkg::bound_t     k2,
  output zmpc_pkg::bound_t     k3,
  output zmpc_pkg::bound_t     k4,
  output zmpc_pkg::bound_t     k5
);
  import zmpc_pkg::*;

  logic     col_all, a_all, b_all, col_np, a_np, b_np;
  logic     a_pres, b_pres, a_mv, b_mv, comp, betw;
  logic     unk;
  ctl_t     ctl_next;
  op_t      op;

  function automatic bound_t map_lo(input bound_t raw, input bound_t code, input logic f);
    return (f && raw == code) ? NEG_INF : raw;
  endfunction

  function automatic bound_t map_hi(input bound_t raw, input bound_t code, input logic f);
    return (f && raw == code) ? POS_INF : raw;
  endfunction

  always_comb begin
    op      = op_t'(mode);
    col_all = null_flags[0];
    a_all   = null_flags[1];
    b_all   = null_flags[2];
    col_np  = null_flags[3];
    a_np    = null_flags[4];
    b_np    = null_flags[5];
    a_pres  = operand_flags[0];
    b_pres  = operand_flags[1];
    a_mv    = operand_flags[2];
    b_mv    = operand_flags[3];
    comp    = operand_flags[4];
    betw    = (mode == OP_BETW) || (mode == OP_NBETW);
    unk     = (col_min == null_code) || (col_max == null_code) ||
              (first_min == null_code) || (first_max == null_code) ||
              (b_pres && ((second_min == null_code) || (second_max == null_code)));
    ctl_next.op      = op;
    ctl_next.demote  = col_np || a_np || (b_pres && b_np);
    ctl_next.decided = 1'b1;
    ctl_next.early   = V_SOME;
    priority if (mode == OP_FALSE) begin
      ctl_next.early = V_NONE;
    end else if (mode == OP_TRUE) begin
      ctl_next.early = V_ALL;
    end else if (mode == OP_ISNULL || mode == OP_NOTNULL) begin
      if (col_all) begin
        ctl_next.early = (mode == OP_ISNULL) ? V_ALL : V_NONE;
      end else if (!col_np) begin
        ctl_next.early = (mode == OP_ISNULL) ? V_NONE : V_ALL;
      end
    end else if (mode > OP_NLIKE) begin
      ctl_next.early = V_SOME;
    end else if (!a_pres || (betw && !b_pres)) begin
      ctl_next.early = V_SOME;
    end else if (col_all || (!a_mv && (a_all || (b_pres && !b_mv && b_all)))) begin
      ctl_next.early = V_NONE;
    end else if (mode == OP_LIKE || mode == OP_NLIKE || a_mv || (b_pres && b_mv) ||
                 !comp || unk) begin
      ctl_next.early = V_SOME;
    end else begin
      ctl_next.decided = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_next;
      fp  <= is_float;
      k0  <= is_float ? map_lo(col_min, minus_inf_code, 1'b1) : (col_min ^ SIGN_BIT) ^ SIGN_BIT;
      k1  <= map_hi(col_max, plus_inf_code, is_float);
      k2  <= map_lo(first_min, minus_inf_code, is_float);
      k3  <= map_hi(first_max, plus_inf_code, is_float);
      k4  <= map_lo(second_min, minus_inf_code, is_float);
      k5  <= map_hi(second_max, plus_inf_code, is_float);
    end
  end

endmodule
`default_nettype wire

[design/zmpc_cmp.sv]
`default_nettype none
module zmpc_cmp (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire zmpc_pkg::ctl_t   ctl_in,
  input  wire logic             fp,
  input  wire zmpc_pkg::bound_t k0,
  input  wire zmpc_pkg::bound_t k1,
  input  wire zmpc_pkg::bound_t k2,
  input  wire zmpc_pkg::bound_t k3,
  input  wire zmpc_pkg::bound_t k4,
  input  wire zmpc_pkg::bound_t k5,
  output zmpc_pkg::ctl_t        ctl,
  output zmpc_pkg::cmp_t        c30,
  output zmpc_pkg::cmp_t        c12,
  output zmpc_pkg::cmp_t        c14,
  output zmpc_pkg::cmp_t        c50,
  output zmpc_pkg::cmp_t        c03
);
  import zmpc_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_in;
      c30 <= compare(k3, k0, fp);
      c12 <= compare(k1, k2, fp);
      c14 <= compare(k1, k4, fp);
      c50 <= compare(k5, k0, fp);
      c03 <= compare(k0, k3, fp);
    end
  end

endmodule
`default_nettype wire

[design/zmpc_decide.sv]
`default_nettype none
module zmpc_decide (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire zmpc_pkg::ctl_t ctl,
  input  wire zmpc_pkg::cmp_t c30,
  input  wire zmpc_pkg::cmp_t c12,
  input  wire zmpc_pkg::cmp_t c14,
  input  wire zmpc_pkg::cmp_t c50,
  input  wire zmpc_pkg::cmp_t c03,
  output zmpc_pkg::verdict_t verdict
);
  import zmpc_pkg::*;

  verdict_t res, verdict_next;
  logic     eqne, le30, le12, le14;

  always_comb begin
    eqne = (ctl.op == OP_EQ) || (ctl.op == OP_NE);
    le30 = c30.lt || c30.eq;
    le12 = c12.lt || c12.eq;
    le14 = c14.lt || c14.eq;
    res  = V_SOME;
    if (ctl.op == OP_BETW || ctl.op == OP_NBETW) begin
      if (le30 && le14) begin
        res = V_ALL;
      end else if (c50.lt || c12.lt) begin
        res = V_NONE;
      end
    end else begin
      if (le30) begin
        if (ctl.op == OP_LT || ctl.op == OP_GE) res = V_NONE;
        if (c30.lt) begin
          if (eqne) res = V_NONE;
          if (ctl.op == OP_GT || ctl.op == OP_LE) res = V_ALL;
        end
      end
      if (le12) begin
        if (ctl.op == OP_GT || ctl.op == OP_LE) res = V_NONE;
        if (c12.lt) begin
          if (eqne) res = V_NONE;
          if (ctl.op == OP_LT || ctl.op == OP_GE) res = V_ALL;
        end
      end
      if (res == V_SOME && eqne && c03.eq && c12.eq) res = V_ALL;
    end
    if (ctl.op == OP_NE || ctl.op == OP_LE || ctl.op == OP_GE || ctl.op == OP_NBETW) begin
      if (res == V_ALL) begin
        res = V_NONE;
      end else if (res == V_NONE) begin
        res = V_ALL;
      end
    end
    if (res == V_ALL && ctl.demote) res = V_SOME;
    verdict_next = ctl.decided ? ctl.early : res;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      verdict <= verdict_next;
    end
  end

endmodule
`default_nettype wire

[design/zone_map_predicate_check.sv]
`default_nettype none
// Stages: front bound registers, then compare registers, then the verdict register.
// Throughput: one word per cycle unless out_stall holds the pipeline; bound mapping,
// 64-bit compares and the verdict logic each take one pipeline stage.
// Reset: rst clears stage valid bits and loads the three sentinel registers.
module zone_map_predicate_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  mode,
  input  wire logic        is_float,
  input  wire logic [63:0] col_min,
  input  wire logic [63:0] col_max,
  input  wire logic [63:0] first_min,
  input  wire logic [63:0] first_max,
  input  wire logic [63:0] second_min,
  input  wire logic [63:0] second_max,
  input  wire logic [5:0]  null_flags,
  input  wire logic [4:0]  operand_flags,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       verdict,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import zmpc_pkg::*;

  bound_t   null_code, minus_inf_code, plus_inf_code;
  logic     v1, v2, v3;
  logic     en1, en2, en3;
  ctl_t     ctl1, ctl2;
  logic     fp1;
  bound_t   k0, k1, k2, k3, k4, k5;
  cmp_t     c30, c12, c14, c50, c03;
  verdict_t vd;

  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign cfg_ready = 1'b1;
  assign out_valid = v3;
  assign verdict   = vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      null_code      <= SIGN_BIT;
      minus_inf_code <= SIGN_BIT + 64'd1;
      plus_inf_code  <= SIGN_BIT - 64'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NULL: null_code      <= cfg_data;
        REG_MINF: minus_inf_code <= cfg_data;
        REG_PINF: plus_inf_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  zmpc_front u_front (
    .clk, .en(en1), .mode, .is_float, .col_min, .col_max, .first_min, .first_max,
    .second_min, .second_max, .null_flags, .operand_flags, .null_code,
    .minus_inf_code, .plus_inf_code, .ctl(ctl1), .fp(fp1),
    .k0, .k1, .k2, .k3, .k4, .k5
  );

  zmpc_cmp u_cmp (
    .clk, .en(en2), .ctl_in(ctl1), .fp(fp1), .k0, .k1, .k2, .k3, .k4, .k5,
    .ctl(ctl2), .c30, .c12, .c14, .c50, .c03
  );

  zmpc_decide u_decide (
    .clk, .en(en3), .ctl(ctl2), .c30, .c12, .c14, .c50, .c03, .verdict(vd)
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict))
    else $error("verdict lost under stall");
  a_no_three: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict != 2'd3)
    else $error("illegal verdict");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    v2 && !out_stall |=> v3)
    else $error("stage did not advance");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && v3)
    else $error("stall with empty stage");
`endif

endmodule
`default_nettype wire
